/* hw/rtl/move_buffer_ring_pool_defines.svh */
// Assertion macros for the move buffer ring pool checker.
`ifndef MOVE_BUFFER_RING_POOL_DEFINES_SVH
`define MOVE_BUFFER_RING_POOL_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define MBRP_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mbrp check failed");

// Next-cycle implication, disabled during reset.
`define MBRP_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mbrp check failed");

`endif

/* hw/rtl/mbrp_pkg.sv */
// Shared types and constants for the move buffer ring pool.
`timescale 1ns / 1ps
package mbrp_pkg;

  localparam int DEFAULT_RING_DEPTH = 32;

  localparam int MODE_W = 3;
  localparam int TYPE_W = 4;
  localparam int IDX_W  = 5;
  localparam int CNT_W  = 6;
  localparam int ST_W   = 3;

  localparam logic [MODE_W-1:0] MODE_CLAIM   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_QUEUE   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_GETRUN  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_FREE    = 3'd3;
  localparam logic [MODE_W-1:0] MODE_GETLAST = 3'd4;

  localparam logic [ST_W-1:0] ST_EMPTY   = 3'd0;
  localparam logic [ST_W-1:0] ST_LOADING = 3'd1;
  localparam logic [ST_W-1:0] ST_QUEUED  = 3'd2;
  localparam logic [ST_W-1:0] ST_PENDING = 3'd3;
  localparam logic [ST_W-1:0] ST_RUNNING = 3'd4;

  typedef struct packed {
    logic [ST_W-1:0]   state;
    logic [TYPE_W-1:0] kind;
    logic              live;
  } entry_t;

  typedef struct packed {
    logic accept;
    logic issue;
    logic eval;
    logic wread;
    logic weval;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              walk_start;
    logic              walk_cont;
    logic              walk_live;
  } stat_t;

endpackage

/* hw/rtl/mbrp_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module mbrp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hw/rtl/mbrp_ctrl.sv */
// Sequencing state machine for the move buffer ring pool.
`timescale 1ns / 1ps
module mbrp_ctrl import mbrp_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  output logic  out_valid,
  input  logic  out_ready,
  input  stat_t st,
  output cmd_t  cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ISSUE = 3'd1;
  localparam logic [2:0] S_EVAL  = 3'd2;
  localparam logic [2:0] S_WREAD = 3'd3;
  localparam logic [2:0] S_WEVAL = 3'd4;
  localparam logic [2:0] S_FIN   = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = S_ISSUE;
        end
      end
      S_ISSUE: begin
        cmd.issue = 1'b1;
        if (st.mode == MODE_CLAIM || st.mode == MODE_GETRUN ||
            st.mode == MODE_FREE || st.mode == MODE_GETLAST) begin
          state_next = S_EVAL;
        end else begin
          state_next = S_FIN;
        end
      end
      S_EVAL: begin
        cmd.eval   = 1'b1;
        state_next = st.walk_start ? S_WREAD : S_FIN;
      end
      S_WREAD: begin
        cmd.wread  = 1'b1;
        state_next = st.walk_cont ? S_WEVAL : S_FIN;
      end
      S_WEVAL: begin
        cmd.weval  = 1'b1;
        state_next = st.walk_live ? S_WREAD : S_FIN;
      end
      S_FIN: begin
        // The result goes out only once the output register is free.
        if (!out_valid || out_ready) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

/* hw/rtl/mbrp_dp.sv */
// Ring pointers, free count, entry store and result registers.
`timescale 1ns / 1ps
module mbrp_dp import mbrp_pkg::*; #(
  parameter int RING_DEPTH = DEFAULT_RING_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  cmd_t              cmd,
  output stat_t             st,
  input  logic [MODE_W-1:0] mode,
  input  logic [TYPE_W-1:0] move_type,
  output logic              found,
  output logic [IDX_W-1:0]  entry_index,
  output logic [TYPE_W-1:0] entry_kind,
  output logic [CNT_W-1:0]  free_count
);

  localparam int AW = $clog2(RING_DEPTH);
  localparam int CW = $clog2(RING_DEPTH + 1);

  function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] p);
    return (p == AW'(RING_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  logic [MODE_W-1:0]     mode_q;
  logic [TYPE_W-1:0]     mtype_q;
  logic [AW-1:0]         wp, qp, rp, p;
  logic [CW-1:0]         avail;
  logic [RING_DEPTH-1:0] vld;
  logic                  rd_ok;
  logic                  res_found;
  logic [AW-1:0]         res_idx;
  logic [TYPE_W-1:0]     res_kind;

  logic                  we;
  logic [AW-1:0]         waddr, raddr;
  entry_t                wdata, rdata, ent;
  logic [AW-1:0]         rp_nx, p_nx;
  logic                  running;

  assign rp_nx = ring_next(rp);
  assign p_nx  = ring_next(p);

  // Entries never written since reset read as empty.
  assign ent = rd_ok ? rdata : '0;
  assign running = (ent.state == ST_QUEUED) || (ent.state == ST_PENDING) ||
                   (ent.state == ST_RUNNING);

  assign st.mode       = mode_q;
  assign st.walk_start = (mode_q == MODE_GETLAST) && running;
  assign st.walk_cont  = (p_nx != rp);
  assign st.walk_live  = ent.live;

  mbrp_ram #(
    .WIDTH($bits(entry_t)),
    .DEPTH(RING_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_comb begin
    we    = 1'b0;
    waddr = wp;
    wdata = '0;
    raddr = wp;
    if (cmd.issue) begin
      unique case (mode_q)
        MODE_CLAIM: raddr = wp;
        MODE_QUEUE: begin
          we    = 1'b1;
          waddr = qp;
          wdata = '{state: ST_QUEUED, kind: mtype_q, live: 1'b1};
        end
        MODE_GETRUN, MODE_GETLAST: raddr = rp;
        MODE_FREE: begin
          we    = 1'b1;
          waddr = rp;
          wdata = '0;
          raddr = rp_nx;
        end
        default: ;
      endcase
    end
    if (cmd.eval) begin
      unique case (mode_q)
        MODE_CLAIM: begin
          if (ent.state == ST_EMPTY) begin
            we    = 1'b1;
            waddr = wp;
            wdata = '{state: ST_LOADING, kind: '0, live: 1'b0};
          end
        end
        MODE_GETRUN, MODE_GETLAST: begin
          if (ent.state == ST_QUEUED || ent.state == ST_PENDING) begin
            we    = 1'b1;
            waddr = rp;
            wdata = '{state: ST_RUNNING, kind: ent.kind, live: ent.live};
          end
        end
        MODE_FREE: begin
          // The run pointer has already moved to the next entry here.
          if (ent.state == ST_QUEUED) begin
            we    = 1'b1;
            waddr = rp;
            wdata = '{state: ST_PENDING, kind: ent.kind, live: ent.live};
          end
        end
        default: ;
      endcase
    end
    if (cmd.wread) begin
      raddr = p_nx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      qp    <= '0;
      rp    <= '0;
      avail <= CW'(RING_DEPTH);
      vld   <= '0;
    end else begin
      if (we) begin
        vld[waddr] <= 1'b1;
      end
      if (cmd.issue && mode_q == MODE_QUEUE) begin
        qp <= ring_next(qp);
      end
      if (cmd.issue && mode_q == MODE_FREE) begin
        rp <= rp_nx;
        if (avail != CW'(RING_DEPTH)) begin
          avail <= avail + 1'b1;
        end
      end
      if (cmd.eval && mode_q == MODE_CLAIM && ent.state == ST_EMPTY) begin
        wp <= ring_next(wp);
        if (avail != '0) begin
          avail <= avail - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_ok <= vld[raddr];
    if (cmd.accept) begin
      mode_q  <= mode;
      mtype_q <= move_type;
    end
    if (cmd.issue) begin
      unique case (mode_q)
        MODE_QUEUE: begin
          res_found <= 1'b1;
          res_idx   <= qp;
          res_kind  <= mtype_q;
        end
        MODE_FREE: begin
          res_found <= 1'b1;
          res_idx   <= rp;
          res_kind  <= '0;
        end
        default: begin
          res_found <= 1'b0;
          res_idx   <= '0;
          res_kind  <= '0;
        end
      endcase
    end
    if (cmd.eval) begin
      unique case (mode_q)
        MODE_CLAIM: begin
          res_found <= (ent.state == ST_EMPTY);
          res_idx   <= wp;
          res_kind  <= '0;
        end
        MODE_GETRUN, MODE_GETLAST: begin
          res_found <= running;
          res_idx   <= rp;
          res_kind  <= running ? ent.kind : '0;
          p         <= rp;
        end
        default: ;
      endcase
    end
    if (cmd.weval && ent.live) begin
      p        <= p_nx;
      res_idx  <= p_nx;
      res_kind <= ent.kind;
    end
    if (cmd.load_out) begin
      found       <= res_found;
      entry_index <= IDX_W'(res_idx);
      entry_kind  <= res_kind;
      free_count  <= CNT_W'(avail);
    end
  end

endmodule

/* hw/rtl/move_buffer_ring_pool.sv */
// Claim, get-run and free: the request is taken in idle, then passes issue, eval and finish.
// Queue and unused modes: the request passes issue and then finish, with no eval step.
// Get-last with no running entry acts like get-run; otherwise it walks on from the run entry,
// a read and an eval step per live entry, stopping short of wrapping onto the run entry.
// One request is in flight at a time and every entry access waits on the registered RAM read.
// Reset (rst, synchronous) clears pointers and valid bits, sets the free count to RING_DEPTH.
`timescale 1ns / 1ps
module move_buffer_ring_pool import mbrp_pkg::*; #(
  parameter int RING_DEPTH = DEFAULT_RING_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [MODE_W-1:0] mode,
  input  logic [TYPE_W-1:0] move_type,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              found,
  output logic [IDX_W-1:0]  entry_index,
  output logic [TYPE_W-1:0] entry_kind,
  output logic [CNT_W-1:0]  free_count
);

  cmd_t  cmd;
  stat_t st;

  mbrp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .st       (st),
    .cmd      (cmd)
  );

  mbrp_dp #(
    .RING_DEPTH(RING_DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .st         (st),
    .mode       (mode),
    .move_type  (move_type),
    .found      (found),
    .entry_index(entry_index),
    .entry_kind (entry_kind),
    .free_count (free_count)
  );

endmodule

/* hw/rtl/mbrp_checker.sv */
// Port-level checks for the move buffer ring pool, bound to the top level.
`timescale 1ns / 1ps
`include "move_buffer_ring_pool_defines.svh"
module mbrp_checker import mbrp_pkg::*; #(
  parameter int RING_DEPTH = DEFAULT_RING_DEPTH
) (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic              found,
  input logic [IDX_W-1:0]  entry_index,
  input logic [TYPE_W-1:0] entry_kind,
  input logic [CNT_W-1:0]  free_count
);

  logic [IDX_W+TYPE_W+CNT_W:0] res_bits;

  assign res_bits = {found, entry_index, entry_kind, free_count};

  // A stalled result must stay up and unchanged.
  `MBRP_ASSERT_NXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid)
  `MBRP_ASSERT_NXT(a_out_stable, clk, rst, out_valid && !out_ready, $stable(res_bits))

  // Only one request is worked on at a time.
  `MBRP_ASSERT_NXT(a_one_at_a_time, clk, rst, in_valid && in_ready, !in_ready)

  // The free count never exceeds the ring depth.
  `MBRP_ASSERT_IMP(a_count_bound, clk, rst, out_valid, (RING_DEPTH > 63) || (free_count <= RING_DEPTH))

  // A miss never reports a move kind.
  `MBRP_ASSERT_IMP(a_miss_kind, clk, rst, out_valid && !found, entry_kind == '0)

endmodule

bind move_buffer_ring_pool mbrp_checker #(
  .RING_DEPTH(RING_DEPTH)
) u_mbrp_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .found      (found),
  .entry_index(entry_index),
  .entry_kind (entry_kind),
  .free_count (free_count)
);

/* bench/tb_move_buffer_ring_pool.sv */
// Self-checking testbench for the move buffer ring pool: random handshakes, predicted replies.
`timescale 1ns / 1ps
module tb_move_buffer_ring_pool import mbrp_pkg::*;;

  localparam int DEPTH = DEFAULT_RING_DEPTH;
  localparam int ITEMS = 1500;
  localparam int STUCK_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 2 * DEPTH + 10;
  localparam int QUIET_TAIL = 150;
  localparam int REPORT_MAX = 10;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [TYPE_W-1:0] mtype;
  } ring_req_t;

  typedef struct packed {
    logic              hit;
    logic [IDX_W-1:0]  pos;
    logic [TYPE_W-1:0] kind;
    logic [CNT_W-1:0]  count;
  } slot_reply_t;

  logic              clk;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [MODE_W-1:0] mode = '0;
  logic [TYPE_W-1:0] move_type = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic              found;
  logic [IDX_W-1:0]  entry_index;
  logic [TYPE_W-1:0] entry_kind;
  logic [CNT_W-1:0]  free_count;

  move_buffer_ring_pool #(.RING_DEPTH(DEPTH)) dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .mode        (mode),
    .move_type   (move_type),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .found       (found),
    .entry_index (entry_index),
    .entry_kind  (entry_kind),
    .free_count  (free_count)
  );

  // Shadow copy of the ring used to predict each reply.
  logic [ST_W-1:0]   slot_state [DEPTH];
  logic [TYPE_W-1:0] slot_kind [DEPTH];
  logic              slot_live [DEPTH];
  int                wr_ptr, qu_ptr, run_ptr, free_slots;

  ring_req_t   req_backlog [$];
  slot_reply_t replies_due [$];
  int          work_items = 0;
  int          stim_total = 0;
  int          mismatches = 0;
  int          gap_left = 0;
  int          stall_left = 0;
  int          stuck = 0;
  int          taken = 0;
  int          tick = 0;
  int          idle_pct = 15;
  logic        calm = 1'b0;

  function automatic int ring_step(input int p);
    return (p + 1 < DEPTH) ? p + 1 : 0;
  endfunction

  // A queued or pending run entry starts running; reports whether it runs now.
  function automatic logic promote_run();
    if (slot_state[run_ptr] == ST_QUEUED || slot_state[run_ptr] == ST_PENDING) begin
      slot_state[run_ptr] = ST_RUNNING;
    end
    return slot_state[run_ptr] == ST_RUNNING;
  endfunction

  function automatic void ring_apply(input logic [MODE_W-1:0] m, input logic [TYPE_W-1:0] t);
    slot_reply_t r;
    int p, nx, steps;
    r = '0;
    case (m)
      MODE_CLAIM: begin
        r.pos = IDX_W'(wr_ptr);
        if (slot_state[wr_ptr] == ST_EMPTY) begin
          slot_kind[wr_ptr] = '0;
          slot_live[wr_ptr] = 1'b0;
          slot_state[wr_ptr] = ST_LOADING;
          if (free_slots > 0) free_slots--;
          wr_ptr = ring_step(wr_ptr);
          r.hit = 1'b1;
        end
      end
      MODE_QUEUE: begin
        r.pos = IDX_W'(qu_ptr);
        slot_kind[qu_ptr] = t;
        slot_live[qu_ptr] = 1'b1;
        slot_state[qu_ptr] = ST_QUEUED;
        qu_ptr = ring_step(qu_ptr);
        r.hit = 1'b1;
        r.kind = t;
      end
      MODE_GETRUN: begin
        r.pos = IDX_W'(run_ptr);
        if (promote_run()) begin
          r.hit = 1'b1;
          r.kind = slot_kind[run_ptr];
        end
      end
      MODE_FREE: begin
        r.pos = IDX_W'(run_ptr);
        slot_state[run_ptr] = ST_EMPTY;
        slot_kind[run_ptr] = '0;
        slot_live[run_ptr] = 1'b0;
        run_ptr = ring_step(run_ptr);
        if (slot_state[run_ptr] == ST_QUEUED) slot_state[run_ptr] = ST_PENDING;
        if (free_slots < DEPTH) free_slots++;
        r.hit = 1'b1;
      end
      MODE_GETLAST: begin
        r.pos = IDX_W'(run_ptr);
        if (promote_run()) begin
          // Walk forward over live entries, stopping short of wrapping onto the run entry.
          p = run_ptr;
          nx = ring_step(p);
          steps = 0;
          while (steps < DEPTH && slot_live[nx] && nx != run_ptr) begin
            p = nx;
            nx = ring_step(p);
            steps++;
          end
          r.hit = 1'b1;
          r.pos = IDX_W'(p);
          r.kind = slot_kind[p];
        end
      end
      default: ;
    endcase
    r.count = CNT_W'(free_slots);
    replies_due.push_back(r);
  endfunction

  task automatic add_req(input logic [MODE_W-1:0] m, input logic [TYPE_W-1:0] t);
    ring_req_t q;
    q.mode = m;
    q.mtype = t;
    req_backlog.push_back(q);
    if (m <= MODE_GETLAST) work_items++;
  endtask

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Driver: presents queued requests and predicts each one as it is accepted.
  always @(posedge clk) begin : drive
    ring_req_t q;
    if (rst) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_valid && in_ready) ring_apply(mode, move_type);
      if (!(in_valid && !in_ready)) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (req_backlog.size() == 0) begin
          in_valid <= 1'b0;
        end else if (!calm && $urandom_range(0, 99) < idle_pct) begin
          gap_left = $urandom_range(0, 6);
          in_valid <= 1'b0;
        end else begin
          q = req_backlog.pop_front();
          in_valid <= 1'b1;
          mode <= q.mode;
          move_type <= q.mtype;
        end
      end
    end
  end

  // Monitor: checks every accepted reply against the oldest prediction.
  always @(posedge clk) begin : watch
    slot_reply_t got, want;
    if (rst) begin
      out_ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && out_ready) begin
        got = {found, entry_index, entry_kind, free_count};
        if (replies_due.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_MAX) begin
            $display("unexpected reply: found=%0d idx=%0d kind=%0d free=%0d",
                     got.hit, got.pos, got.kind, got.count);
          end
        end else begin
          want = replies_due.pop_front();
          if (got.hit !== want.hit || got.pos !== want.pos ||
              got.kind !== want.kind || got.count !== want.count) begin
            mismatches++;
            if (mismatches <= REPORT_MAX) begin
              $display("reply mismatch: expected found=%0d idx=%0d kind=%0d free=%0d",
                       want.hit, want.pos, want.kind, want.count);
              $display("                actual   found=%0d idx=%0d kind=%0d free=%0d",
                       got.hit, got.pos, got.kind, got.count);
            end
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 99) < idle_pct) begin
        stall_left = $urandom_range(0, 6);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // The idle rate is redrawn as 0, 15 or 30 percent by a tick counter; the tail starts no new idling.
  always @(posedge clk) begin
    if (rst) begin
      stuck <= 0;
      taken <= 0;
      tick <= 0;
    end else begin
      tick <= tick + 1;
      if (tick % 256 == 255) idle_pct <= 15 * $urandom_range(0, 2);
      if ((in_valid && in_ready) || (out_valid && out_ready)) stuck <= 0;
      else stuck <= stuck + 1;
      if (in_valid && in_ready) taken <= taken + 1;
      calm <= (taken + QUIET_TAIL >= stim_total);
    end
  end

  initial begin : run
    int pick, n;
    for (int i = 0; i < DEPTH; i++) begin
      slot_state[i] = ST_EMPTY;
      slot_kind[i] = '0;
      slot_live[i] = 1'b0;
    end
    wr_ptr = 0;
    qu_ptr = 0;
    run_ptr = 0;
    free_slots = DEPTH;

    // Directed opening: free with a full count, empty run entry, unused modes,
    // claim/queue with extreme kinds, walks, and a claim that finds its entry taken.
    add_req(MODE_FREE, 4'hf);
    add_req(MODE_GETRUN, 4'hf);
    add_req(MODE_GETLAST, 4'h0);
    for (int m = int'(MODE_GETLAST) + 1; m < 2 ** MODE_W; m++) add_req(MODE_W'(m), 4'hf);
    add_req(MODE_CLAIM, 4'hf);
    add_req(MODE_QUEUE, 4'hf);
    add_req(MODE_CLAIM, 4'h0);
    add_req(MODE_QUEUE, 4'h0);
    add_req(MODE_CLAIM, 4'h5);
    add_req(MODE_QUEUE, 4'ha);
    add_req(MODE_CLAIM, 4'ha);
    add_req(MODE_QUEUE, 4'h5);
    add_req(MODE_GETRUN, 4'h0);
    add_req(MODE_GETLAST, 4'h0);
    add_req(MODE_FREE, 4'h0);
    add_req(MODE_GETLAST, 4'hf);
    add_req(MODE_FREE, 4'h0);
    add_req(MODE_FREE, 4'h0);
    add_req(MODE_FREE, 4'h0);
    add_req(MODE_QUEUE, 4'h3);
    add_req(MODE_CLAIM, 4'h0);
    add_req(MODE_GETRUN, 4'h0);

    // Mostly producer/consumer traffic, with ring fills, drains and stray requests.
    while (work_items < ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        n = $urandom_range(1, 8);
        repeat (n) begin
          add_req(MODE_CLAIM, TYPE_W'($urandom_range(0, 15)));
          add_req(MODE_QUEUE, TYPE_W'($urandom_range(0, 15)));
        end
      end else if (pick < 70) begin
        add_req(MODE_GETRUN, TYPE_W'($urandom_range(0, 15)));
        if ($urandom_range(0, 1)) add_req(MODE_GETLAST, TYPE_W'($urandom_range(0, 15)));
        add_req(MODE_FREE, TYPE_W'($urandom_range(0, 15)));
      end else if (pick < 78) begin
        n = $urandom_range(DEPTH - 12, DEPTH);
        repeat (n) add_req(MODE_QUEUE, TYPE_W'($urandom_range(0, 15)));
        add_req(MODE_GETLAST, TYPE_W'($urandom_range(0, 15)));
        add_req(MODE_GETRUN, TYPE_W'($urandom_range(0, 15)));
      end else if (pick < 86) begin
        n = $urandom_range(1, DEPTH);
        repeat (n) add_req(MODE_FREE, TYPE_W'($urandom_range(0, 15)));
      end else begin
        add_req(MODE_W'($urandom_range(0, 2 ** MODE_W - 1)), TYPE_W'($urandom_range(0, 15)));
      end
    end
    stim_total = req_backlog.size();

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    while ((req_backlog.size() != 0 || in_valid || replies_due.size() != 0) &&
           stuck < STUCK_LIMIT) begin
      @(posedge clk);
    end
    if (stuck >= STUCK_LIMIT) begin
      $display("tb: failure");
    end else begin
      repeat (DRAIN_CYCLES) @(posedge clk);
      if (mismatches == 0 && replies_due.size() == 0) begin
        $display("tb: success");
      end else begin
        $display("tb: failure");
      end
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+hw/rtl
hw/rtl/mbrp_pkg.sv
hw/rtl/mbrp_ram.sv
hw/rtl/mbrp_ctrl.sv
hw/rtl/mbrp_dp.sv
hw/rtl/move_buffer_ring_pool.sv
hw/rtl/mbrp_checker.sv
bench/tb_move_buffer_ring_pool.sv
